FILE: rtl/extendible_hash_table_defines.svh
// assertion macros for the extendible hash table
`ifndef EXTENDIBLE_HASH_TABLE_DEFINES_SVH
`define EXTENDIBLE_HASH_TABLE_DEFINES_SVH

`ifndef ASSERT_OFF
`define EHT_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) else $error(msg);
`define EHT_ASSERT_NEVER(lbl, clk_s, rst_s, cond, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) !(cond)) else $error(msg);
`else
`define EHT_ASSERT(lbl, clk_s, rst_s, prop, msg)
`define EHT_ASSERT_NEVER(lbl, clk_s, rst_s, cond, msg)
`endif

`endif

FILE: rtl/eht_pkg.sv
package eht_pkg;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_FIND   = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  localparam int CAP_W    = 4;
  localparam int DEPTH_W  = 4;
  localparam int COUNT_W  = 9;
  localparam int VALUE_W  = 32;
  localparam int OPCODE_W = 2;
  localparam int STATUS_W = 2;
  localparam logic [CAP_W-1:0] CAP_RESET = 4'd8;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIR,
    S_ROW,
    S_EVAL,
    S_DBL_RD,
    S_DBL_WR,
    S_ALLOC,
    S_WR_OLD,
    S_WR_NEW,
    S_RED_RD,
    S_RED_WR,
    S_DONE
  } eht_state_t;

endpackage

FILE: rtl/extendible_hash_table.sv
// extendible hash table, key used as its own hash
// input channel in_valid/in_ready carries one item: opcode (insert, find,
// remove), key and value_in. output channel out_valid/out_ready returns one
// result item per input item: status, value_out, global_depth, bucket_count.
// cfg_valid/cfg_ready writes bucket_capacity; always ready, write while idle.
// one item at a time: a find, remove or plain insert goes through the
// directory read, the bucket row read, the evaluation and the output
// register before the next item is taken. a split first doubles the
// directory if the bucket's local depth has reached the global depth,
// reading and writing each entry, then writes the old and new buckets,
// sweeps the directory to redirect entries and retries the lookup; a split chain repeats that per split.
// the bucket memory holds one whole bucket per row, read and written as a
// whole, so a bucket scan costs one read.
// the result sits in an output register; a new item is accepted while it
// waits, and the block stalls before its next result until it is taken.
// reset sets depth to zero, one bucket and capacity 8 at once; no clearing
// pass: directory entry 0 always names bucket 0, bucket 0 reads as empty
// until first written, and every other entry is written before it is read.
module extendible_hash_table import eht_pkg::*; #(
  parameter int MAX_GLOBAL_DEPTH = 8,
  parameter int BUCKET_SLOTS = 8,
  parameter int KEY_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [OPCODE_W-1:0] opcode,
  input  logic [KEY_WIDTH-1:0] key,
  input  logic [VALUE_W-1:0]  value_in,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] status,
  output logic [VALUE_W-1:0]  value_out,
  output logic [DEPTH_W-1:0]  global_depth,
  output logic [COUNT_W-1:0]  bucket_count,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CAP_W-1:0]    cfg_data
);

`include "extendible_hash_table_defines.svh"

  localparam int DW = MAX_GLOBAL_DEPTH;
  localparam int DIR_SIZE = 1 << DW;
  localparam int LDW = $clog2(MAX_GLOBAL_DEPTH + 1);
  localparam int BW = DW + 1;
  localparam int SW = (BUCKET_SLOTS > 1) ? $clog2(BUCKET_SLOTS) : 1;
  localparam int CW = $clog2(BUCKET_SLOTS + 1);

  typedef struct packed {
    logic [BUCKET_SLOTS-1:0][KEY_WIDTH-1:0] keys;
    logic [BUCKET_SLOTS-1:0][VALUE_W-1:0]   vals;
    logic [BUCKET_SLOTS-1:0]                valid;
    logic [LDW-1:0]                         ld;
  } row_t;

  eht_state_t state, state_next;

  logic [DW-1:0] dir_mem [DIR_SIZE];
  row_t          row_mem [DIR_SIZE];
  logic [DW-1:0] dir_q;
  logic          dir_zero;
  row_t          row_q;

  logic          dir_re, dir_we, row_re, row_we;
  logic [DW-1:0] dir_raddr, dir_waddr, dir_wdata, row_raddr, row_waddr;
  row_t          row_wdata;

  logic [OPCODE_W-1:0]  op;
  logic [KEY_WIDTH-1:0] k;
  logic [VALUE_W-1:0]   v;
  logic [CAP_W-1:0]     cap;
  logic [LDW-1:0]       depth;
  logic [BW-1:0]        bused;
  logic [DW-1:0]        b, nb;
  logic                 b_empty, b0_init;
  logic [BW-1:0]        cnt;
  logic [STATUS_W-1:0]  res_status;
  logic [VALUE_W-1:0]   res_value;

  logic [KEY_WIDTH+DW-1:0] kx;
  logic [DW-1:0]        didx, dir_val, b_now;
  logic [BW-1:0]        size;
  logic [CW-1:0]        eff;
  row_t                 rv, row_old, row_new;
  logic [BUCKET_SLOTS-1:0] mv;
  logic [KEY_WIDTH-1:0] ksh;
  logic [BW-1:0]        csh;
  logic                 hit, free_any;
  logic [SW-1:0]        hit_idx, free_idx;
  logic [CW-1:0]        count;

  always_ff @(posedge clk) begin
    if (dir_we) begin
      dir_mem[dir_waddr] <= dir_wdata;
    end
    if (dir_re) begin
      dir_q <= dir_mem[dir_raddr];
      dir_zero <= (dir_raddr == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (row_we) begin
      row_mem[row_waddr] <= row_wdata;
    end
    if (row_re) begin
      row_q <= row_mem[row_raddr];
    end
  end

  eht_bucket_scan #(
    .BUCKET_SLOTS(BUCKET_SLOTS),
    .KEY_WIDTH(KEY_WIDTH),
    .SW(SW),
    .CW(CW)
  ) u_scan (
    .keys(rv.keys),
    .valid(rv.valid),
    .key(k),
    .hit(hit),
    .hit_idx(hit_idx),
    .free_any(free_any),
    .free_idx(free_idx),
    .count(count)
  );

  always_comb begin
    kx = {{DW{1'b0}}, k};
    didx = kx[DW-1:0] & ~({DW{1'b1}} << depth);
    dir_val = dir_zero ? '0 : dir_q;
    b_now = dir_val;
    size = BW'(1) << depth;
    if (cap == '0) begin
      eff = CW'(1);
    end else if (32'(cap) > BUCKET_SLOTS) begin
      eff = CW'(BUCKET_SLOTS);
    end else begin
      eff = CW'(cap);
    end
    rv = row_q;
    if (b_empty) begin
      rv.valid = '0;
      rv.ld = '0;
    end
    for (int i = 0; i < BUCKET_SLOTS; i++) begin
      ksh = rv.keys[i] >> rv.ld;
      mv[i] = rv.valid[i] && ksh[0];
    end
    csh = cnt >> rv.ld;
    row_old = rv;
    row_old.valid = rv.valid & ~mv;
    row_old.ld = rv.ld + LDW'(1);
    row_new = rv;
    row_new.valid = mv;
    row_new.ld = rv.ld + LDW'(1);
  end

  always_comb begin
    state_next = state;
    dir_re = 1'b0;
    dir_raddr = cnt[DW-1:0];
    dir_we = 1'b0;
    dir_waddr = cnt[DW-1:0];
    dir_wdata = dir_val;
    row_re = 1'b0;
    row_raddr = b_now;
    row_we = 1'b0;
    row_waddr = b;
    row_wdata = rv;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_DIR;
        end
      end
      S_DIR: begin
        dir_re = 1'b1;
        dir_raddr = didx;
        state_next = S_ROW;
      end
      S_ROW: begin
        row_re = 1'b1;
        state_next = S_EVAL;
      end
      S_EVAL: begin
        state_next = S_DONE;
        case (op)
          OP_INSERT: begin
            if (hit) begin
              row_we = 1'b1;
              row_wdata.vals[hit_idx] = v;
            end else if ((count < eff) && free_any) begin
              row_we = 1'b1;
              row_wdata.keys[free_idx] = k;
              row_wdata.vals[free_idx] = v;
              row_wdata.valid[free_idx] = 1'b1;
            end else if (rv.ld >= depth) begin
              if (depth < LDW'(MAX_GLOBAL_DEPTH)) begin
                state_next = S_DBL_RD;
              end
            end else begin
              state_next = S_ALLOC;
            end
          end
          OP_REMOVE: begin
            if (hit) begin
              row_we = 1'b1;
              row_wdata.valid[hit_idx] = 1'b0;
            end
          end
          default: begin
          end
        endcase
      end
      S_DBL_RD: begin
        dir_re = 1'b1;
        state_next = S_DBL_WR;
      end
      S_DBL_WR: begin
        dir_we = 1'b1;
        dir_waddr = DW'(cnt + size);
        state_next = (cnt == size - BW'(1)) ? S_ALLOC : S_DBL_RD;
      end
      S_ALLOC: begin
        state_next = (bused >= BW'(DIR_SIZE)) ? S_DONE : S_WR_OLD;
      end
      S_WR_OLD: begin
        row_we = 1'b1;
        row_wdata = row_old;
        state_next = S_WR_NEW;
      end
      S_WR_NEW: begin
        row_we = 1'b1;
        row_waddr = nb;
        row_wdata = row_new;
        state_next = S_RED_RD;
      end
      S_RED_RD: begin
        dir_re = 1'b1;
        state_next = S_RED_WR;
      end
      S_RED_WR: begin
        if ((dir_val == b) && csh[0]) begin
          dir_we = 1'b1;
          dir_wdata = nb;
        end
        state_next = (cnt == size - BW'(1)) ? S_DIR : S_RED_RD;
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= CAP_RESET;
      depth <= '0;
      bused <= BW'(1);
      b0_init <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        cap <= cfg_data;
      end
      if (row_we && (row_waddr == '0)) begin
        b0_init <= 1'b1;
      end
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op <= opcode;
            k <= key;
            v <= value_in;
          end
        end
        S_ROW: begin
          b <= b_now;
          b_empty <= (b_now == '0) && !b0_init;
        end
        S_EVAL: begin
          cnt <= '0;
          res_value <= '0;
          res_status <= ST_NOT_FOUND;
          case (op)
            OP_INSERT: begin
              if (hit || ((count < eff) && free_any)) begin
                res_status <= ST_OK;
              end else if ((rv.ld >= depth) && (depth >= LDW'(MAX_GLOBAL_DEPTH))) begin
                res_status <= ST_FULL;
              end
            end
            OP_FIND: begin
              if (hit) begin
                res_status <= ST_OK;
                res_value <= rv.vals[hit_idx];
              end
            end
            OP_REMOVE: begin
              if (hit) begin
                res_status <= ST_OK;
              end
            end
            default: begin
            end
          endcase
        end
        S_DBL_WR: begin
          cnt <= cnt + BW'(1);
          if (cnt == size - BW'(1)) begin
            depth <= depth + LDW'(1);
          end
        end
        S_ALLOC: begin
          if (bused >= BW'(DIR_SIZE)) begin
            res_status <= ST_FULL;
          end else begin
            nb <= bused[DW-1:0];
            bused <= bused + BW'(1);
          end
        end
        S_WR_NEW: begin
          cnt <= '0;
        end
        S_RED_WR: begin
          cnt <= cnt + BW'(1);
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            status <= res_status;
            value_out <= res_value;
            global_depth <= DEPTH_W'(depth);
            bucket_count <= COUNT_W'(bused);
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign in_ready = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  `EHT_ASSERT(a_depth_max, clk, rst, depth <= LDW'(MAX_GLOBAL_DEPTH), "depth above max")
  `EHT_ASSERT(a_buckets_fit, clk, rst, (bused >= BW'(1)) && (bused <= size), "bucket count out of range")
  `EHT_ASSERT_NEVER(a_row_alloc, clk, rst, row_we && (BW'(row_waddr) >= bused), "write to unallocated bucket")
  `EHT_ASSERT(a_dir_sweep, clk, rst, dir_we |-> ((state == S_DBL_WR) || (state == S_RED_WR)), "directory write outside sweep")

endmodule

FILE: rtl/eht_bucket_scan.sv
module eht_bucket_scan import eht_pkg::*; #(
  parameter int BUCKET_SLOTS = 8,
  parameter int KEY_WIDTH = 32,
  parameter int SW = 3,
  parameter int CW = 4
) (
  input  logic [BUCKET_SLOTS-1:0][KEY_WIDTH-1:0] keys,
  input  logic [BUCKET_SLOTS-1:0]                valid,
  input  logic [KEY_WIDTH-1:0]                   key,
  output logic                                   hit,
  output logic [SW-1:0]                          hit_idx,
  output logic                                   free_any,
  output logic [SW-1:0]                          free_idx,
  output logic [CW-1:0]                          count
);

  always_comb begin
    hit = 1'b0;
    hit_idx = '0;
    free_any = 1'b0;
    free_idx = '0;
    count = '0;
    for (int i = BUCKET_SLOTS - 1; i >= 0; i--) begin
      if (valid[i] && (keys[i] == key)) begin
        hit = 1'b1;
        hit_idx = SW'(i);
      end
      if (!valid[i]) begin
        free_any = 1'b1;
        free_idx = SW'(i);
      end
    end
    for (int i = 0; i < BUCKET_SLOTS; i++) begin
      count = count + CW'(valid[i]);
    end
  end

endmodule
